/* hw/rtl/assert_macros.svh */
// Assertion shorthands used by the checker.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tcba_pkg.sv */
`default_nettype none

package tcba_pkg;

    // Field and store widths
    localparam int ADDR_W      = 13;
    localparam int PTR_W       = 14;
    localparam int CNT_W       = 13;
    localparam int CLS_W       = 2;
    localparam int WORDS_W     = 7;
    localparam int STORE_DEPTH = 8192;

    // Pool geometry
    localparam int POOL_WORDS  = 8192;
    localparam int SMALL_WORDS = 5;
    localparam int MID_WORDS   = 6;
    localparam int LARGE_WORDS = 7;

    // Free-word sum and its ceiling
    localparam int SUM_W    = 22;
    localparam int FREE_MAX = 16383;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;

    // Command and class codes
    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_SMALL = 2'd1;
    localparam logic [1:0] CLS_MID   = 2'd2;
    localparam logic [1:0] CLS_LARGE = 2'd3;

    localparam logic [PTR_W-1:0] NULL_PTR = {PTR_W{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef enum logic [2:0] {
        OP_FAIL,
        OP_CARVE,
        OP_POP,
        OP_SPLIT,
        OP_FREE
    } op_t;

    // Write port of the link store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PTR_W-1:0]  data;
    } link_wr_t;

    // Write port of the class tag store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CLS_W-1:0]  data;
    } tag_wr_t;

    // Block size in words for a class code
    function automatic logic [WORDS_W-1:0] class_words(input logic [CLS_W-1:0] cls);
        logic [WORDS_W-1:0] w;
        case (cls)
            CLS_SMALL: w = WORDS_W'(SMALL_WORDS);
            CLS_MID:   w = WORDS_W'(MID_WORDS);
            default:   w = WORDS_W'(LARGE_WORDS);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tcba_ram.sv */
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module tcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/tcba_core.sv */
`default_nettype none

// Allocator control: decides the action at accept, reads the stores,
// then updates heads, counts and stores and registers the result.
module tcba_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_command,
    input  logic [tcba_pkg::CLS_W-1:0]     in_size_class,
    input  logic [tcba_pkg::ADDR_W-1:0]    in_block_addr,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tcba_pkg::ADDR_W-1:0]    out_result_addr,
    output logic                           out_ok,
    output logic [tcba_pkg::PTR_W-1:0]     out_free_words,
    output logic [tcba_pkg::CNT_W-1:0]     out_frag_count,
    output logic [tcba_pkg::ADDR_W-1:0]    link_raddr,
    input  logic [tcba_pkg::PTR_W-1:0]     link_rdata,
    output tcba_pkg::link_wr_t             link_wr,
    output logic [tcba_pkg::ADDR_W-1:0]    tag_raddr,
    input  logic [tcba_pkg::CLS_W-1:0]     tag_rdata,
    output tcba_pkg::tag_wr_t              tag_wr
);

    import tcba_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [PTR_W-1:0]  raw_next_reg, raw_next_next;
    logic [PTR_W-1:0]  raw_left_reg, raw_left_next;
    logic [PTR_W-1:0]  head_reg [3];
    logic [PTR_W-1:0]  head_next [3];
    logic [CNT_W-1:0]  cnt_reg [3];
    logic [CNT_W-1:0]  cnt_next [3];
    logic [CNT_W-1:0]  split_reg, split_next;

    // Pending request, held through the execute cycle
    op_t               ex_op_reg;
    logic [CLS_W-1:0]  ex_cls_reg;
    logic [CLS_W-1:0]  ex_src_reg;
    logic [ADDR_W-1:0] ex_addr_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              ok_reg;

    logic              accept;
    logic              exec_fire;
    logic              clr_done;
    op_t               dec_op;
    logic [CLS_W-1:0]  dec_src;
    logic [PTR_W-1:0]  dec_head;
    logic [PTR_W-1:0]  src_head;
    logic [PTR_W-1:0]  tag_head;
    logic              own_nz;
    logic [2:0]        cnt_nz;
    logic              raw_fit;
    logic [WORDS_W-1:0] in_words;
    logic [WORDS_W-1:0] ex_words;
    logic [ADDR_W-1:0] res_addr;
    logic              res_ok;
    logic [SUM_W-1:0]  free_sum;

    assign accept    = in_valid && in_ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign clr_done  = (clr_cnt_reg == {ADDR_W{1'b1}});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_done) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_EXEC;
            ST_EXEC:  if (exec_fire) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = out_valid_reg;
    end

    // Serving order at accept: carve, own list, split a larger block
    always_comb
    begin
        in_words = class_words(in_size_class);
        raw_fit  = (raw_left_reg >= PTR_W'(in_words));
        own_nz   = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            cnt_nz[k] = (cnt_reg[k] != '0);
            if (in_size_class == CLS_W'(k + 1)) own_nz = cnt_nz[k];
        end
        dec_op  = OP_FAIL;
        dec_src = in_size_class;
        if (in_command == CMD_FREE)
        begin
            dec_op = OP_FREE;
        end
        else if (in_size_class != CLS_NONE)
        begin
            if (raw_fit)
            begin
                dec_op = OP_CARVE;
            end
            else if (own_nz)
            begin
                dec_op = OP_POP;
            end
            else if (in_size_class == CLS_SMALL && cnt_nz[2])
            begin
                dec_op  = OP_SPLIT;
                dec_src = CLS_LARGE;
            end
            else if (in_size_class == CLS_SMALL && cnt_nz[1])
            begin
                dec_op  = OP_SPLIT;
                dec_src = CLS_MID;
            end
            else if (in_size_class == CLS_MID && cnt_nz[2])
            begin
                dec_op  = OP_SPLIT;
                dec_src = CLS_LARGE;
            end
        end
    end

    // Head selection for the decoded list, the pending list and the freed tag
    always_comb
    begin
        dec_head = NULL_PTR;
        src_head = NULL_PTR;
        tag_head = NULL_PTR;
        for (int k = 0; k < 3; k++)
        begin
            if (dec_src == CLS_W'(k + 1))    dec_head = head_reg[k];
            if (ex_src_reg == CLS_W'(k + 1)) src_head = head_reg[k];
            if (tag_rdata == CLS_W'(k + 1))  tag_head = head_reg[k];
        end
    end

    // Read addresses stay fixed while a request waits in execute
    always_comb
    begin
        if (state_reg == ST_EXEC)
        begin
            link_raddr = src_head[ADDR_W-1:0];
            tag_raddr  = ex_addr_reg;
        end
        else
        begin
            link_raddr = dec_head[ADDR_W-1:0];
            tag_raddr  = in_block_addr;
        end
    end

    // Execute: update registers, write stores, form the result
    always_comb
    begin
        raw_next_next = raw_next_reg;
        raw_left_next = raw_left_reg;
        split_next    = split_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        link_wr       = '0;
        tag_wr        = '0;
        res_addr      = '0;
        res_ok        = 1'b0;
        ex_words      = class_words(ex_cls_reg);
        if (state_reg == ST_CLEAR)
        begin
            tag_wr.we   = 1'b1;
            tag_wr.addr = clr_cnt_reg;
            tag_wr.data = CLS_NONE;
        end
        if (exec_fire)
        begin
            case (ex_op_reg)
                OP_CARVE:
                begin
                    res_addr      = raw_next_reg[ADDR_W-1:0];
                    res_ok        = 1'b1;
                    raw_next_next = raw_next_reg + PTR_W'(ex_words);
                    raw_left_next = raw_left_reg - PTR_W'(ex_words);
                    tag_wr.we     = 1'b1;
                    tag_wr.addr   = raw_next_reg[ADDR_W-1:0];
                    tag_wr.data   = ex_cls_reg;
                end
                OP_POP, OP_SPLIT:
                begin
                    res_addr = src_head[ADDR_W-1:0];
                    res_ok   = 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (ex_src_reg == CLS_W'(k + 1))
                        begin
                            head_next[k] = link_rdata;
                            cnt_next[k]  = cnt_reg[k] - CNT_W'(1);
                        end
                    end
                    if (ex_op_reg == OP_SPLIT)
                    begin
                        tag_wr.we   = 1'b1;
                        tag_wr.addr = src_head[ADDR_W-1:0];
                        tag_wr.data = ex_cls_reg;
                        split_next  = split_reg + CNT_W'(1);
                    end
                end
                OP_FREE:
                begin
                    if (tag_rdata != CLS_NONE)
                    begin
                        res_ok       = 1'b1;
                        link_wr.we   = 1'b1;
                        link_wr.addr = ex_addr_reg;
                        link_wr.data = tag_head;
                        for (int k = 0; k < 3; k++)
                        begin
                            if (tag_rdata == CLS_W'(k + 1))
                            begin
                                head_next[k] = PTR_W'(ex_addr_reg);
                                cnt_next[k]  = cnt_reg[k] + CNT_W'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            raw_next_reg  <= '0;
            raw_left_reg  <= PTR_W'(POOL_WORDS);
            split_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                head_reg[k] <= NULL_PTR;
                cnt_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            raw_next_reg <= raw_next_next;
            raw_left_reg <= raw_left_next;
            split_reg    <= split_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_op_reg   <= dec_op;
            ex_cls_reg  <= in_size_class;
            ex_src_reg  <= dec_src;
            ex_addr_reg <= in_block_addr;
        end
        if (exec_fire)
        begin
            out_addr_reg <= res_addr;
            ok_reg       <= res_ok;
        end
    end

    // Free words from the settled registers, saturated
    always_comb
    begin
        free_sum = SUM_W'(raw_left_reg)
                 + SUM_W'(cnt_reg[0]) * SUM_W'(SMALL_WORDS)
                 + SUM_W'(cnt_reg[1]) * SUM_W'(MID_WORDS)
                 + SUM_W'(cnt_reg[2]) * SUM_W'(LARGE_WORDS);
        out_free_words = (free_sum > SUM_W'(FREE_MAX)) ? PTR_W'(FREE_MAX)
                                                       : free_sum[PTR_W-1:0];
    end

    assign out_result_addr = out_addr_reg;
    assign out_ok          = ok_reg;
    assign out_frag_count  = split_reg;

endmodule

`default_nettype wire

/* hw/rtl/three_class_block_allocator_top.sv */
// Flow: a request is accepted, its store reads land in the next cycle and the result
// is registered, raising m_axis_tvalid, at the end of the execute cycle once the output is free.
// Requests: one at a time, each held through the read-modify-write of the
// link and tag stores; a held result stalls only the execute cycle.
// Reset: rst_n is asynchronous, active low; afterwards the tag store is swept to
// zero one entry per cycle with s_axis_tready low.
`default_nettype none

module three_class_block_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // size_class[1:0], block_addr[14:2], zero fill
    input  logic [tcba_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command[0]
    input  logic [tcba_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // result_addr[12:0], ok[13], free_words[27:14], frag_count[40:28], zero fill
    output logic [tcba_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import tcba_pkg::*;

    localparam int M_USED_W = ADDR_W + 1 + PTR_W + CNT_W;

    logic [ADDR_W-1:0] link_raddr;
    logic [PTR_W-1:0]  link_rdata;
    link_wr_t          link_wr;
    logic [ADDR_W-1:0] tag_raddr;
    logic [CLS_W-1:0]  tag_rdata;
    tag_wr_t           tag_wr;
    logic [ADDR_W-1:0] result_addr;
    logic              ok;
    logic [PTR_W-1:0]  free_words;
    logic [CNT_W-1:0]  frag_count;

    // Next-block links
    tcba_ram #(
        .WIDTH (PTR_W),
        .DEPTH (STORE_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_wr.we),
        .waddr (link_wr.addr),
        .wdata (link_wr.data),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Class tags
    tcba_ram #(
        .WIDTH (CLS_W),
        .DEPTH (STORE_DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_wr.we),
        .waddr (tag_wr.addr),
        .wdata (tag_wr.data),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    tcba_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_command      (s_axis_tuser[0]),
        .in_size_class   (s_axis_tdata[CLS_W-1:0]),
        .in_block_addr   (s_axis_tdata[CLS_W+ADDR_W-1:CLS_W]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_result_addr (result_addr),
        .out_ok          (ok),
        .out_free_words  (free_words),
        .out_frag_count  (frag_count),
        .link_raddr      (link_raddr),
        .link_rdata      (link_rdata),
        .link_wr         (link_wr),
        .tag_raddr       (tag_raddr),
        .tag_rdata       (tag_rdata),
        .tag_wr          (tag_wr)
    );

    // Result packing
    assign m_axis_tdata = {{(M_TDATA_W - M_USED_W){1'b0}},
                           frag_count, free_words, ok, result_addr};

endmodule

`default_nettype wire

/* hw/rtl/tcba_checker.sv */
`default_nettype none

`include "assert_macros.svh"

// Port-level checks of the allocator.
module tcba_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tcba_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import tcba_pkg::*;

    logic              res_ok;
    logic [ADDR_W-1:0] res_addr;
    logic              out_stall;
    logic              in_fire;

    assign res_ok    = m_axis_tdata[ADDR_W];
    assign res_addr  = m_axis_tdata[ADDR_W-1:0];
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    // A stalled result stays up
    `ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped while stalled")

    // A stalled result keeps its payload, including the live totals
    `ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "payload changed while stalled")

    // One request at a time: busy right after a transaction
    `ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "request taken during execute")

    // Failed requests report address zero
    `ASSERT_IMPL(a_fail_addr_zero, m_axis_tvalid && !res_ok, res_addr == '0, "failed nonzero addr")

endmodule

bind three_class_block_allocator_top tcba_checker u_tcba_checker (.*);

`default_nettype wire
